FILE: design/rlb_pkg.sv
// shared constants and types for the rgb565 linear blend block
// no dependencies
`default_nettype none
package rlb_pkg;
  localparam int unsigned FracW = 16;
  localparam int unsigned ColorW = 16;
  localparam int unsigned ChanW = 8;
  // magnitude of a clamped fraction (positive denominator)
  localparam int unsigned MagW = FracW - 1;
  // |diff| * n, diff magnitude below 256
  localparam int unsigned ProdW = ChanW + MagW;
  localparam int unsigned NumLanes = 3;
  // one quotient bit per divide stage
  localparam int unsigned DivStages = ChanW;
  localparam int unsigned LaneLat = DivStages + 1;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [MagW-1:0] mag_t;

  typedef struct packed {
    logic  en;
    mag_t  numer;
    mag_t  denom;
  } lane_ctl_t;

  function automatic chan_t widen5(input logic [4:0] c);
    widen5 = {c, c[4:2]};
  endfunction

  function automatic chan_t widen6(input logic [5:0] c);
    widen6 = {c, c[5:4]};
  endfunction
endpackage
`default_nettype wire

FILE: design/rlb_if.sv
// handshake channels for the rgb565 linear blend block
// depends on rlb_pkg
`default_nettype none
interface rlb_in_if;
  logic                              valid;
  logic                              ready;
  logic [rlb_pkg::ColorW-1:0]        start_color;
  logic [rlb_pkg::ColorW-1:0]        end_color;
  logic signed [rlb_pkg::FracW-1:0]  step_position;
  logic signed [rlb_pkg::FracW-1:0]  step_count;
  modport source (output valid, start_color, end_color, step_position, step_count,
                  input ready);
  modport sink (input valid, start_color, end_color, step_position, step_count,
                output ready);
endinterface

interface rlb_out_if;
  logic                       valid;
  logic                       ready;
  logic [rlb_pkg::ColorW-1:0] blended_color;
  modport source (output valid, blended_color, input ready);
  modport sink (input valid, blended_color, output ready);
endinterface
`default_nettype wire

FILE: design/rlb_lane.sv
// one color channel: multiply, pipelined restoring divide, signed add
// depends on rlb_pkg
`default_nettype none
module rlb_lane (
  input  wire logic               clk_i,
  input  wire rlb_pkg::lane_ctl_t ctl_i,
  input  wire rlb_pkg::chan_t     a_i,
  input  wire rlb_pkg::chan_t     b_i,
  output rlb_pkg::chan_t          res_o
);
  localparam int unsigned PW = rlb_pkg::ProdW;
  localparam int unsigned DS = rlb_pkg::DivStages;

  logic           neg_q   [0:DS];
  rlb_pkg::chan_t a_q     [0:DS];
  rlb_pkg::mag_t  den_q   [0:DS];
  logic [PW-1:0]  rem_q   [0:DS];
  rlb_pkg::chan_t quo_q   [0:DS];

  logic           neg_d;
  rlb_pkg::chan_t mag_d;

  always_comb begin
    neg_d = b_i < a_i;
    mag_d = neg_d ? (a_i - b_i) : (b_i - a_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      neg_q[0] <= neg_d;
      a_q[0]   <= a_i;
      den_q[0] <= ctl_i.denom;
      rem_q[0] <= mag_d * ctl_i.numer;
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < DS; s++) begin : g_div
    localparam int unsigned Sh = DS - 1 - s;
    logic [PW-1:0] trial;
    logic          take;
    assign trial = PW'(den_q[s]) << Sh;
    assign take  = rem_q[s] >= trial;
    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        neg_q[s+1] <= neg_q[s];
        a_q[s+1]   <= a_q[s];
        den_q[s+1] <= den_q[s];
        rem_q[s+1] <= take ? (rem_q[s] - trial) : rem_q[s];
        quo_q[s+1] <= quo_q[s] | (take ? (rlb_pkg::chan_t'(1) << Sh) : '0);
      end
    end
  end

  // quotient magnitude never carries the result out of 0..255
  assign res_o = neg_q[DS] ? (a_q[DS] - quo_q[DS]) : (a_q[DS] + quo_q[DS]);
endmodule
`default_nettype wire

FILE: design/rgb565_linear_blend.sv
// top level of the rgb565 linear blend block: lanes plus merge and output stage
// depends on rlb_pkg, rlb_if, rlb_lane
`default_nettype none
// Blends two RGB565 colors by step_position/step_count, one request per clock.
// A non-positive step_count returns start_color unchanged; otherwise the
// position is clamped to 0..step_count, each channel is widened to 8 bits and
// interpolated with a signed quotient truncated toward zero, and the result is
// repacked. Three channel lanes run side by side; each multiplies and then
// divides with one quotient bit per stage, so a request passes through 1
// multiply stage, 8 divide stages and 1 output register. The pipeline holds
// while the output waits, and accepts a new request every cycle that the
// output register is free or being drained.
module rgb565_linear_blend (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rlb_in_if.sink    req_i,
  rlb_out_if.source res_o
);
  localparam int unsigned Lat = rlb_pkg::LaneLat;

  logic                 adv;
  logic                 vld_q    [0:Lat-1];
  logic                 byp_q    [0:Lat-1];
  logic [15:0]          c0_q     [0:Lat-1];
  logic                 out_vld_q;
  logic [15:0]          out_q;

  rlb_pkg::lane_ctl_t   ctl;
  rlb_pkg::chan_t       a_ch [0:rlb_pkg::NumLanes-1];
  rlb_pkg::chan_t       b_ch [0:rlb_pkg::NumLanes-1];
  rlb_pkg::chan_t       r_ch [0:rlb_pkg::NumLanes-1];
  logic                 bypass;

  // pipeline moves whenever the output slot can take a result
  assign adv         = !out_vld_q || res_o.ready;
  assign req_i.ready = adv;

  // clamp the fraction; a non-positive denominator bypasses the lanes
  always_comb begin
    bypass    = req_i.step_count <= 0;
    ctl.en    = adv;
    ctl.denom = rlb_pkg::mag_t'(req_i.step_count);
    if (req_i.step_position < 0) begin
      ctl.numer = '0;
    end else if (req_i.step_position > req_i.step_count) begin
      ctl.numer = rlb_pkg::mag_t'(req_i.step_count);
    end else begin
      ctl.numer = rlb_pkg::mag_t'(req_i.step_position);
    end
    a_ch[0] = rlb_pkg::widen5(req_i.start_color[15:11]);
    a_ch[1] = rlb_pkg::widen6(req_i.start_color[10:5]);
    a_ch[2] = rlb_pkg::widen5(req_i.start_color[4:0]);
    b_ch[0] = rlb_pkg::widen5(req_i.end_color[15:11]);
    b_ch[1] = rlb_pkg::widen6(req_i.end_color[10:5]);
    b_ch[2] = rlb_pkg::widen5(req_i.end_color[4:0]);
  end

  for (genvar l = 0; l < rlb_pkg::NumLanes; l++) begin : g_lane
    rlb_lane u_lane (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .a_i   (a_ch[l]),
      .b_i   (b_ch[l]),
      .res_o (r_ch[l])
    );
  end

  // valid bits follow the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) vld_q[i] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= req_i.valid;
      for (int i = 1; i < Lat; i++) vld_q[i] <= vld_q[i-1];
      out_vld_q <= vld_q[Lat-1];
    end
  end

  // bypass flag and raw start color ride alongside
  always_ff @(posedge clk_i) begin
    if (adv) begin
      byp_q[0] <= bypass;
      c0_q[0]  <= req_i.start_color;
      for (int i = 1; i < Lat; i++) begin
        byp_q[i] <= byp_q[i-1];
        c0_q[i]  <= c0_q[i-1];
      end
      // merge: repack lanes by dropping low bits, or pass start color
      out_q <= byp_q[Lat-1] ? c0_q[Lat-1]
                            : {r_ch[0][7:3], r_ch[1][7:2], r_ch[2][7:3]};
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.blended_color = out_q;
endmodule
`default_nettype wire

FILE: bench/rgb565_linear_blend_tb.sv
// testbench for the rgb565 linear blend block: random and directed color blends
// checked against a behavioral blend predictor; depends on rlb_pkg and rlb_if
`default_nettype none
module rgb565_linear_blend_tb;

  typedef struct packed {
    logic [rlb_pkg::ColorW-1:0]       c0;
    logic [rlb_pkg::ColorW-1:0]       c1;
    logic signed [rlb_pkg::FracW-1:0] pos;
    logic signed [rlb_pkg::FracW-1:0] cnt;
  } blend_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rlb_in_if  req_if ();
  rlb_out_if res_if ();

  rgb565_linear_blend DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .res_o (res_if.source)
  );

  always #5 clk_i = ~clk_i;

  blend_req_t                 pending_reqs[$];
  logic [rlb_pkg::ColorW-1:0] expected_colors[$];
  int unsigned     send_idle_pct = 29;
  int unsigned     recv_idle_pct = 79;
  bit              hold_sender = 1'b0;
  bit              req_accepted = 1'b0;
  int unsigned     mismatches = 0;

  // interpolate one widened 8-bit channel, quotient truncated toward zero
  function automatic logic [7:0] lerp_chan(input int a, input int b, input int n,
                                           input int d);
    int v;
    v = a + ((b - a) * n) / d;
    return v[7:0];
  endfunction

  function automatic logic [rlb_pkg::ColorW-1:0] blend_color(input blend_req_t r);
    int n, d;
    int a[3], b[3];
    logic [7:0] q[3];
    d = int'(r.cnt);
    n = int'(r.pos);
    if (d <= 0) return r.c0;
    if (n < 0) n = 0;
    if (n > d) n = d;
    a[0] = int'({r.c0[15:11], r.c0[15:13]});
    a[1] = int'({r.c0[10:5], r.c0[10:9]});
    a[2] = int'({r.c0[4:0], r.c0[4:2]});
    b[0] = int'({r.c1[15:11], r.c1[15:13]});
    b[1] = int'({r.c1[10:5], r.c1[10:9]});
    b[2] = int'({r.c1[4:0], r.c1[4:2]});
    for (int i = 0; i < 3; i++) q[i] = lerp_chan(a[i], b[i], n, d);
    return {q[0][7:3], q[1][7:2], q[2][7:3]};
  endfunction

  // driver: at most one request offered per falling edge, held until accepted
  initial begin
    req_if.valid = 1'b0;
    req_if.start_color = '0;
    req_if.end_color = '0;
    req_if.step_position = '0;
    req_if.step_count = '0;
    res_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // move on only once the held request was taken at the last rising edge
      if (!req_if.valid || req_accepted) begin
        if (!hold_sender && pending_reqs.size() > 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          blend_req_t r;
          r = pending_reqs.pop_front();
          req_if.valid <= 1'b1;
          req_if.start_color <= r.c0;
          req_if.end_color <= r.c1;
          req_if.step_position <= r.pos;
          req_if.step_count <= r.cnt;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // prediction on acceptance, checking on each result
  always @(posedge clk_i) begin
    req_accepted = rst_ni && req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        blend_req_t r;
        r.c0 = req_if.start_color;
        r.c1 = req_if.end_color;
        r.pos = req_if.step_position;
        r.cnt = req_if.step_count;
        expected_colors.push_back(blend_color(r));
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time,
                   res_if.blended_color);
          mismatches++;
        end else begin
          logic [rlb_pkg::ColorW-1:0] e;
          e = expected_colors.pop_front();
          if (res_if.blended_color !== e) begin
            $display("%0t: blended_color mismatch, expected %h, actual %h", $time, e,
                     res_if.blended_color);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic blend_req_t mk(input logic [15:0] c0, input logic [15:0] c1,
                                    input logic [15:0] p, input logic [15:0] d);
    blend_req_t r;
    r.c0 = c0; r.c1 = c1; r.pos = p; r.cnt = d;
    return r;
  endfunction

  // mostly positive counts, half of them small, with positions near the valid range
  function automatic blend_req_t rand_req();
    blend_req_t r;
    int k;
    r.c0 = 16'($urandom);
    r.c1 = 16'($urandom);
    k = int'($urandom_range(9));
    if (k < 5) begin
      r.cnt = 16'($urandom_range(1, 64));
      r.pos = 16'($signed($urandom_range(0, 80)) - 8);
    end else if (k < 8) begin
      r.cnt = 16'($urandom_range(1, 32767));
      r.pos = 16'($urandom_range(0, r.cnt + 100));
    end else begin
      r.cnt = 16'($urandom);
      r.pos = 16'($urandom);
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_if.valid || expected_colors.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, pass-through, clamps, endpoints
    pending_reqs.push_back(mk(16'h0000, 16'hFFFF, 16'd1, 16'd2));
    pending_reqs.push_back(mk(16'hFFFF, 16'h0000, 16'd1, 16'd2));
    pending_reqs.push_back(mk(16'h1234, 16'hABCD, 16'd5, 16'd0));
    pending_reqs.push_back(mk(16'h1234, 16'hABCD, 16'd5, 16'h8000));
    pending_reqs.push_back(mk(16'h1234, 16'hABCD, 16'd5, 16'hFFFF));
    pending_reqs.push_back(mk(16'h1234, 16'hABCD, 16'h8000, 16'd7));
    pending_reqs.push_back(mk(16'h1234, 16'hABCD, 16'hFFFF, 16'd7));
    pending_reqs.push_back(mk(16'h1234, 16'hABCD, 16'h7FFF, 16'd7));
    pending_reqs.push_back(mk(16'h1234, 16'hABCD, 16'd7, 16'd7));
    pending_reqs.push_back(mk(16'h1234, 16'hABCD, 16'd0, 16'd7));
    pending_reqs.push_back(mk(16'hF800, 16'h07E0, 16'd1, 16'h7FFF));
    pending_reqs.push_back(mk(16'h001F, 16'hFFE0, 16'h7FFE, 16'h7FFF));
    pending_reqs.push_back(mk(16'hFFFF, 16'h0000, 16'h4000, 16'h7FFF));
    pending_reqs.push_back(mk(16'h0000, 16'hFFFF, 16'd1, 16'd1));
    pending_reqs.push_back(mk(16'h5555, 16'hAAAA, 16'd3, 16'd9));
    for (int i = 0; i < 600; i++) pending_reqs.push_back(rand_req());
    wait_drained();
    // sender holds off until all results are back, then swap idling
    hold_sender = 1'b1;
    send_idle_pct = 79;
    recv_idle_pct = 29;
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b0;
    for (int i = 0; i < 650; i++) pending_reqs.push_back(rand_req());
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 650; i++) pending_reqs.push_back(rand_req());
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
design/rlb_pkg.sv
design/rlb_if.sv
design/rlb_lane.sv
design/rgb565_linear_blend.sv
bench/rgb565_linear_blend_tb.sv
